>>> design/rqrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring queue package
// Command and status codes, field widths and parameter defaults shared by
// the ring queue design.
// ----------------------------------------------------------------------------
package rqrr_pkg;

    // Parameter defaults
    localparam int DEPTH_DEFAULT      = 16;
    localparam int ENTRY_BITS_DEFAULT = 32;

    // Fixed field widths
    localparam int CMD_BITS    = 3;
    localparam int ENTRY_W     = 32;
    localparam int OFFSET_BITS = 4;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 4;
    localparam int IDX_BITS    = 4;
    localparam int LEN_BITS    = 5;
    localparam int RING_MAX    = 16;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 40;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_PUSH     = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP      = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_BACK = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_DUMP     = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_STATUS   = 3'd6;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

endpackage

>>> design/ring_queue_with_revoke_and_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring queue with revoke and remove
// Circular queue with push, pop, pop_back, clear, remove_at, dump and status
// commands, run by a small sequencer around a two-port slot memory.
// ----------------------------------------------------------------------------
// Sequence: push, clear and status pass S_EXEC and S_EMIT; pop and pop_back add
// S_RDWAIT for the registered memory read; remove_at adds one S_SHIFT_RD read and
// one S_SHIFT_WR write per shift step; dump runs S_DUMP_RD, S_DUMP_OUT per entry.
// Throughput: one request at a time; the next one is taken once the last result is in
// the output register. Reset (synchronous, active low) empties the queue and sets
// ring_len to its maximum; the slot memory is not cleared.
module ring_queue_with_revoke_and_remove #(
    parameter int DEPTH      = rqrr_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_BITS = rqrr_pkg::ENTRY_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: ring_len
    input  logic                              i_cfg_wr_en,
    input  logic [rqrr_pkg::LEN_BITS-1:0]     i_cfg_wr_data,
    // request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // fields from bit 0: cmd[2:0], entry_in[34:3], offset[38:35], zero fill
    input  logic [rqrr_pkg::S_DATA_BITS-1:0]  i_s_tdata,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // fields from bit 0: status[1:0], entry_out[33:2], count[37:34],
    // is_full[38], zero fill
    output logic [rqrr_pkg::M_DATA_BITS-1:0]  o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int LEN_MAX   = (DEPTH < rqrr_pkg::RING_MAX) ? DEPTH : rqrr_pkg::RING_MAX;
    localparam int AW        = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
    localparam int SLOT_BITS = (ENTRY_BITS < rqrr_pkg::ENTRY_W) ? ENTRY_BITS
                                                                 : rqrr_pkg::ENTRY_W;
    localparam int IW = rqrr_pkg::IDX_BITS;
    localparam int LW = rqrr_pkg::LEN_BITS;

    localparam logic [LW-1:0] LEN_TOP = LW'(LEN_MAX);
    localparam logic [LW-1:0] LEN_MIN = LW'(2);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_RDWAIT   = 3'd2;
    localparam logic [2:0] S_EMIT     = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_DUMP_RD  = 3'd6;
    localparam logic [2:0] S_DUMP_OUT = 3'd7;

    // Registers
    logic [2:0]                             r_state,  n_state;
    logic [LW-1:0]                          r_len,    n_len;
    logic [IW-1:0]                          r_head,   n_head;
    logic [IW-1:0]                          r_tail,   n_tail;
    logic [IW-1:0]                          r_walk,   n_walk;
    logic [rqrr_pkg::CMD_BITS-1:0]          r_cmd,    n_cmd;
    logic [rqrr_pkg::ENTRY_W-1:0]           r_entry,  n_entry;
    logic [rqrr_pkg::OFFSET_BITS-1:0]       r_offset, n_offset;
    logic [rqrr_pkg::STATUS_BITS-1:0]       r_res_st, n_res_st;
    logic [SLOT_BITS-1:0]                   r_res_e,  n_res_e;
    logic                                   r_m_valid, n_m_valid;
    logic [rqrr_pkg::STATUS_BITS-1:0]       r_m_st,   n_m_st;
    logic [rqrr_pkg::ENTRY_W-1:0]           r_m_e,    n_m_e;
    logic [rqrr_pkg::COUNT_BITS-1:0]        r_m_cnt,  n_m_cnt;
    logic                                   r_m_full, n_m_full;
    logic                                   r_m_last, n_m_last;

    // Slot memory
    logic [SLOT_BITS-1:0]                   r_mem [LEN_MAX];
    logic [SLOT_BITS-1:0]                   r_rd_data;
    logic                                   rd_en;
    logic [IW-1:0]                          rd_idx;
    logic                                   wr_en;
    logic [IW-1:0]                          wr_idx;
    logic [SLOT_BITS-1:0]                   wr_data;

    // Index arithmetic
    logic [LW-1:0]                          held_sum;
    logic [IW-1:0]                          held_cnt;
    logic                                   q_empty;
    logic [IW-1:0]                          head_inc;
    logic [IW-1:0]                          tail_inc;
    logic [IW-1:0]                          tail_dec;
    logic [IW-1:0]                          walk_inc;
    logic [LW-1:0]                          shift_sum;
    logic [IW-1:0]                          shift_dst;
    logic [IW-1:0]                          shift_src;
    logic [LW-1:0]                          cfg_len;
    logic                                   out_free;
    logic                                   s_accept;

    // Advance an index by one around the ring
    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] sum;
        sum = {1'b0, idx} + LW'(1);
        if (sum >= len) begin
            sum = sum - len;
        end
        return sum[IW-1:0];
    endfunction

    // Step an index back by one around the ring
    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] dif;
        dif = (idx == '0) ? (len - LW'(1)) : ({1'b0, idx} - LW'(1));
        return dif[IW-1:0];
    endfunction

    assign out_free = !r_m_valid || i_m_tready;
    assign s_accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // Entry count and ring positions
    always_comb begin
        held_sum = {1'b0, r_tail} + r_len - {1'b0, r_head};
        if (held_sum >= r_len) begin
            held_sum = held_sum - r_len;
        end
        held_cnt  = held_sum[IW-1:0];
        q_empty   = (r_head == r_tail);
        head_inc  = wrap_inc(r_head, r_len);
        tail_inc  = wrap_inc(r_tail, r_len);
        tail_dec  = wrap_dec(r_tail, r_len);
        walk_inc  = wrap_inc(r_walk, r_len);
        shift_sum = {1'b0, r_head} + {1'b0, r_walk};
        if (shift_sum >= r_len) begin
            shift_sum = shift_sum - r_len;
        end
        shift_dst = shift_sum[IW-1:0];
        shift_src = wrap_dec(shift_dst, r_len);
    end

    // Saturate the written ring length
    always_comb begin
        if (i_cfg_wr_data < LEN_MIN) begin
            cfg_len = LEN_MIN;
        end else if (i_cfg_wr_data > LEN_TOP) begin
            cfg_len = LEN_TOP;
        end else begin
            cfg_len = i_cfg_wr_data;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_head    = r_head;
        n_tail    = r_tail;
        n_walk    = r_walk;
        n_cmd     = r_cmd;
        n_entry   = r_entry;
        n_offset  = r_offset;
        n_res_st  = r_res_st;
        n_res_e   = r_res_e;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_st    = r_m_st;
        n_m_e     = r_m_e;
        n_m_cnt   = r_m_cnt;
        n_m_full  = r_m_full;
        n_m_last  = r_m_last;
        rd_en     = 1'b0;
        rd_idx    = r_head;
        wr_en     = 1'b0;
        wr_idx    = r_tail;
        wr_data   = r_entry[SLOT_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                // Hold the request fields
                if (s_accept) begin
                    n_cmd    = i_s_tdata[2:0];
                    n_entry  = i_s_tdata[34:3];
                    n_offset = i_s_tdata[38:35];
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_st = rqrr_pkg::ST_OK;
                n_res_e  = '0;
                n_state  = S_EMIT;
                unique case (r_cmd)
                    rqrr_pkg::CMD_PUSH: begin
                        if (tail_inc == r_head) begin
                            n_res_st = rqrr_pkg::ST_FULL;
                        end else begin
                            wr_en  = 1'b1;
                            n_tail = tail_inc;
                        end
                    end
                    rqrr_pkg::CMD_POP: begin
                        if (q_empty) begin
                            n_res_st = rqrr_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_idx  = r_head;
                            n_head  = head_inc;
                            n_state = S_RDWAIT;
                        end
                    end
                    rqrr_pkg::CMD_POP_BACK: begin
                        if (q_empty) begin
                            n_res_st = rqrr_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_idx  = tail_dec;
                            n_tail  = tail_dec;
                            n_state = S_RDWAIT;
                        end
                    end
                    rqrr_pkg::CMD_CLEAR: begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    rqrr_pkg::CMD_REMOVE: begin
                        if (q_empty) begin
                            n_res_st = rqrr_pkg::ST_EMPTY;
                        end else if (r_offset >= held_cnt) begin
                            n_res_st = rqrr_pkg::ST_RANGE;
                        end else if (r_offset == '0) begin
                            n_head = head_inc;
                        end else begin
                            n_walk  = r_offset;
                            n_state = S_SHIFT_RD;
                        end
                    end
                    rqrr_pkg::CMD_DUMP: begin
                        if (q_empty) begin
                            n_res_st = rqrr_pkg::ST_EMPTY;
                        end else begin
                            n_walk  = r_head;
                            n_state = S_DUMP_RD;
                        end
                    end
                    default: begin
                        // status and unused codes report only
                        n_res_st = rqrr_pkg::ST_OK;
                    end
                endcase
            end

            S_RDWAIT: begin
                // Capture the slot taken by pop or pop_back
                n_res_e = r_rd_data;
                n_state = S_EMIT;
            end

            S_EMIT: begin
                // Load the single result once the output side is free
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_st    = r_res_st;
                    n_m_e     = rqrr_pkg::ENTRY_W'(r_res_e);
                    n_m_cnt   = held_cnt;
                    n_m_full  = ({1'b0, held_cnt} == (r_len - LW'(1)));
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_SHIFT_RD: begin
                // Read the older neighbor of the slot being filled
                rd_en   = 1'b1;
                rd_idx  = shift_src;
                n_state = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                // Move it one slot toward the tail, then step toward the head
                wr_en   = 1'b1;
                wr_idx  = shift_dst;
                wr_data = r_rd_data;
                n_walk  = r_walk - IW'(1);
                if (r_walk == IW'(1)) begin
                    n_head  = head_inc;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end

            S_DUMP_RD: begin
                rd_en   = 1'b1;
                rd_idx  = r_walk;
                n_state = S_DUMP_OUT;
            end

            S_DUMP_OUT: begin
                // Emit one dumped entry, last when the walk reaches the tail
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_st    = rqrr_pkg::ST_OK;
                    n_m_e     = rqrr_pkg::ENTRY_W'(r_rd_data);
                    n_m_cnt   = held_cnt;
                    n_m_full  = ({1'b0, held_cnt} == (r_len - LW'(1)));
                    n_m_last  = (walk_inc == r_tail);
                    n_walk    = walk_inc;
                    n_state   = (walk_inc == r_tail) ? S_IDLE : S_DUMP_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Ring length write clears the queue
        if (i_cfg_wr_en) begin
            n_len  = cfg_len;
            n_head = '0;
            n_tail = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= LEN_TOP;
            r_head    <= '0;
            r_tail    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_cmd    <= n_cmd;
        r_entry  <= n_entry;
        r_offset <= n_offset;
        r_res_st <= n_res_st;
        r_res_e  <= n_res_e;
        r_m_st   <= n_m_st;
        r_m_e    <= n_m_e;
        r_m_cnt  <= n_m_cnt;
        r_m_full <= n_m_full;
        r_m_last <= n_m_last;
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx[AW-1:0]];
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_full, r_m_cnt, r_m_e, r_m_st};
    assign o_m_tlast  = r_m_last;

endmodule
